@@ design/muskingum_cascade_router_unit_macros.svh @@
// Assertion macros for the Muskingum cascade router.
`ifndef MUSKINGUM_CASCADE_ROUTER_UNIT_MACROS_SVH
`define MUSKINGUM_CASCADE_ROUTER_UNIT_MACROS_SVH
`define MCR_ASSERT(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("assertion failed");
`define MCR_ASSERT_IMP(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("assertion failed");
`endif

@@ design/mcr_pkg.sv @@
// Package: types and constants of the Muskingum cascade router.
package mcr_pkg;
   localparam int MaxSubreaches = 16;
   localparam int IdxW = $clog2(MaxSubreaches);
   localparam int CntW = $clog2(MaxSubreaches + 1);
   localparam logic signed [47:0] VolMax = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [47:0] VolMin = 48'sh8000_0000_0000;

   localparam logic [1:0] CSR_K = 2'd0;
   localparam logic [1:0] CSR_X = 2'd1;
   localparam logic [1:0] CSR_DT = 2'd2;
   localparam logic [1:0] CSR_N = 2'd3;

   typedef enum logic [10:0] {
      ST_IDLE  = 11'b00000000001,
      ST_PREP  = 11'b00000000010,
      ST_DIVX  = 11'b00000000100,
      ST_DIVZ  = 11'b00000001000,
      ST_RDV   = 11'b00000010000,
      ST_MX    = 11'b00000100000,
      ST_MZ    = 11'b00001000000,
      ST_ACC   = 11'b00010000000,
      ST_UPD   = 11'b00100000000,
      ST_OUT   = 11'b01000000000,
      ST_PRE2  = 11'b10000000000
   } state_type;

   function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
      if (v > 50'(VolMax)) return VolMax;
      if (v < 50'(VolMin)) return VolMin;
      return v[47:0];
   endfunction
endpackage

@@ design/muskingum_cascade_router_unit.sv @@
// Muskingum cascade router: coefficient divider, shared multiplier, volume store.
// One inflow beat yields its outflow beat after routing through N active subreaches.
// Two 64-step restoring divisions give Cx and Cz. They are skipped when the denominator
// is zero. Each subreach then takes a volume read, a Cx and a Cz product on one shared
// 48x32 multiply split in two 24-bit halves, and the update. req_tready is low while
// busy and while an outflow beat waits.
`include "muskingum_cascade_router_unit_macros.svh"
module muskingum_cascade_router_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] inflow_volume
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [47:0] outflow_volume
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);
   localparam int IW = mcr_pkg::IdxW;

   logic [15:0] k_ff, x_ff;
   logic [16:0] dt_ff;
   logic [4:0]  n_ff;
   mcr_pkg::state_type state_ff, state_in;

   logic signed [47:0] vol_mem [mcr_pkg::MaxSubreaches];
   logic [mcr_pkg::MaxSubreaches-1:0] vvalid_ff;
   logic signed [47:0] vol_rd_ff;
   logic [IW-1:0] idx_ff;
   logic [mcr_pkg::CntW-1:0] last_ff;
   logic signed [47:0] flow_ff, acc_ff, out_ff;
   logic signed [49:0] mac_ff;
   logic signed [31:0] cx_ff, cz_ff;
   logic [6:0]  cnt_ff;
   logic [33:0] den_ff;
   logic [63:0] quo_ff;
   logic [34:0] rem_ff;
   logic [63:0] dnum_ff;
   logic        negx_ff, zero_ff;
   logic        rsp_valid_ff;
   logic        half_ff;

   assign csr_ready = 1'b1;
   assign req_tready = (state_ff == mcr_pkg::ST_IDLE) && !rsp_valid_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = out_ff;

   // Shared multiplier: one 24-bit half of |a| times |c|, high half first.
   logic signed [47:0] mul_a;
   logic signed [31:0] mul_c;
   logic [48:0] ma;
   logic [31:0] mc;
   logic [23:0] mhalf;
   logic [55:0] prod;
   logic [56:0] p_hi_ff;
   logic        mneg;
   always_comb begin
      mul_a = (state_ff == mcr_pkg::ST_MX) ? flow_ff : vol_rd_ff;
      mul_c = (state_ff == mcr_pkg::ST_MX) ? cx_ff : cz_ff;
      ma = mul_a[47] ? 49'(-{mul_a[47], mul_a}) : 49'({1'b0, mul_a});
      mc = mul_c[31] ? 32'(-mul_c) : 32'(mul_c);
      mneg = mul_a[47] ^ mul_c[31];
      mhalf = half_ff ? ma[23:0] : ma[47:24];
      prod = 56'(mhalf) * 56'(mc);
   end
   logic [56:0] low_sum;
   logic [49:0] mag_r;
   logic signed [49:0] term;
   always_comb begin
      low_sum = 57'({p_hi_ff[5:0], 24'd0}) + 57'(prod) + 57'(1) * (57'd1 << 29);
      mag_r = 50'(p_hi_ff[56:6]) + 50'(low_sum[56:30]);
      term = mneg ? -$signed(mag_r) : $signed(mag_r);
   end

   logic [34:0] trial;
   always_comb trial = {rem_ff[33:0], dnum_ff[63]} - 35'(den_ff);

   logic signed [49:0] newvol;
   always_comb newvol = 50'(vol_rd_ff) + 50'(flow_ff) - 50'(acc_ff);

   logic [32:0] half_dt, kx, num;
   logic [33:0] k1x;
   always_comb begin
      half_dt = 33'(dt_ff) << 15;
      kx = 33'(k_ff) * 33'(x_ff);
      k1x = 34'(k_ff) * 34'(17'h10000 - 17'(x_ff));
      num = (kx > half_dt) ? kx - half_dt : half_dt - kx;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mcr_pkg::ST_IDLE: if (req_tvalid && req_tready) state_in = mcr_pkg::ST_PREP;
         mcr_pkg::ST_PREP: state_in = zero_ff ? mcr_pkg::ST_RDV : mcr_pkg::ST_DIVX;
         mcr_pkg::ST_DIVX: if (cnt_ff == 7'd63) state_in = mcr_pkg::ST_PRE2;
         mcr_pkg::ST_PRE2: state_in = mcr_pkg::ST_DIVZ;
         mcr_pkg::ST_DIVZ: if (cnt_ff == 7'd63) state_in = mcr_pkg::ST_RDV;
         mcr_pkg::ST_RDV:  state_in = mcr_pkg::ST_MX;
         mcr_pkg::ST_MX:   if (half_ff) state_in = mcr_pkg::ST_MZ;
         mcr_pkg::ST_MZ:   if (half_ff) state_in = mcr_pkg::ST_UPD;
         mcr_pkg::ST_ACC:  state_in = mcr_pkg::ST_UPD;
         mcr_pkg::ST_UPD:  state_in = (5'(idx_ff) + 5'd1 == 5'(last_ff)) ?
                                      mcr_pkg::ST_OUT : mcr_pkg::ST_RDV;
         mcr_pkg::ST_OUT:  state_in = mcr_pkg::ST_IDLE;
         default:          state_in = mcr_pkg::ST_IDLE;
      endcase
   end

   logic [63:0] mag64;
   always_comb mag64 = quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mcr_pkg::ST_IDLE;
         k_ff <= 16'd300;
         x_ff <= 16'd6554;
         dt_ff <= 17'd300;
         n_ff <= 5'd11;
         vvalid_ff <= '0;
         rsp_valid_ff <= 1'b0;
         half_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid) begin
            unique case (csr_index)
               mcr_pkg::CSR_K:  k_ff <= csr_data[15:0];
               mcr_pkg::CSR_X:  x_ff <= csr_data[15:0];
               mcr_pkg::CSR_DT: dt_ff <= csr_data[16:0];
               mcr_pkg::CSR_N:  n_ff <= csr_data[4:0];
               default: ;
            endcase
         end
         if (rsp_valid_ff && rsp_tready) rsp_valid_ff <= 1'b0;
         if (state_ff == mcr_pkg::ST_OUT) rsp_valid_ff <= 1'b1;
         if (state_ff == mcr_pkg::ST_MX || state_ff == mcr_pkg::ST_MZ) half_ff <= !half_ff;
         if (state_ff == mcr_pkg::ST_UPD) vvalid_ff[idx_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         mcr_pkg::ST_IDLE: begin
            flow_ff <= 48'(req_tdata);
            idx_ff <= '0;
            last_ff <= (n_ff == 5'd0) ? mcr_pkg::CntW'(1) :
                       (n_ff > 5'(mcr_pkg::MaxSubreaches)) ?
                       mcr_pkg::CntW'(mcr_pkg::MaxSubreaches) : mcr_pkg::CntW'(n_ff);
            den_ff <= 34'(half_dt) + k1x;
            zero_ff <= (34'(half_dt) + k1x) == 34'd0;
         end
         mcr_pkg::ST_PREP: begin
            negx_ff <= kx > half_dt;
            dnum_ff <= (64'(num) << 30) + 64'(den_ff >> 1);
            rem_ff <= '0;
            quo_ff <= '0;
            cnt_ff <= '0;
            cx_ff <= '0;
            cz_ff <= '0;
         end
         mcr_pkg::ST_DIVX, mcr_pkg::ST_DIVZ: begin
            // Restoring division; den/2 is already added to the dividend for rounding.
            cnt_ff <= cnt_ff + 7'd1;
            dnum_ff <= dnum_ff << 1;
            if (!trial[34]) begin
               rem_ff <= trial;
               quo_ff <= {quo_ff[62:0], 1'b1};
            end else begin
               rem_ff <= {rem_ff[33:0], dnum_ff[63]};
               quo_ff <= {quo_ff[62:0], 1'b0};
            end
         end
         mcr_pkg::ST_PRE2: begin
            if (negx_ff) cx_ff <= (mag64 > 64'h8000_0000) ? 32'sh8000_0000 : -$signed(mag64[31:0]);
            else cx_ff <= (mag64 > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(mag64[31:0]);
            dnum_ff <= (64'(dt_ff) << 46) + 64'(den_ff >> 1);
            rem_ff <= '0;
            quo_ff <= '0;
            cnt_ff <= '0;
         end
         mcr_pkg::ST_RDV: begin
            if (cnt_ff == 7'd64) cz_ff <= (mag64 > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF :
                                         $signed(mag64[31:0]);
            cnt_ff <= '0;
            vol_rd_ff <= vvalid_ff[idx_ff] ? vol_mem[idx_ff] : 48'sd0;
            p_hi_ff <= '0;
         end
         mcr_pkg::ST_MX, mcr_pkg::ST_MZ: begin
            if (!half_ff) p_hi_ff <= 57'(prod);
            else begin
               p_hi_ff <= '0;
               if (state_ff == mcr_pkg::ST_MX) mac_ff <= term;
               else acc_ff <= mcr_pkg::sat48(mac_ff + term);
            end
         end
         mcr_pkg::ST_UPD: begin
            vol_mem[idx_ff] <= mcr_pkg::sat48(newvol);
            flow_ff <= acc_ff;
            idx_ff <= idx_ff + IW'(1);
         end
         mcr_pkg::ST_OUT: out_ff <= flow_ff;
         default: ;
      endcase
   end

   `MCR_ASSERT(a_busy_not_ready, !(req_tready && state_ff != mcr_pkg::ST_IDLE))
   `MCR_ASSERT_IMP(a_out_valid, state_ff == mcr_pkg::ST_OUT, rsp_tvalid)
   `MCR_ASSERT_IMP(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
endmodule
